// ----- rtl/core/bfsp_pkg.sv -----
package bfsp_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 1024;
	localparam int WEIGHT_BITS  = 16;

	localparam int VTX_W      = $clog2(MAX_VERTICES);
	localparam int VCNT_W     = $clog2(MAX_VERTICES + 1);
	localparam int EADDR_W    = $clog2(MAX_EDGES);
	localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
	localparam int DIST_W     = 32;
	localparam int FIELD_VW   = 5;
	localparam int CMD_W      = 2;
	localparam int CFG_W      = 6;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

	localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(MAX_VERTICES);

	typedef struct packed {
		logic [VTX_W-1:0]       src;
		logic [VTX_W-1:0]       dst;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_rec_t;

	typedef struct packed {
		logic               accept;
		logic               init;
		logic               edge_rd;
		logic               node_rd;
		logic               calc;
		logic               upd;
		logic               check;
		logic               out_rd;
		logic               out_emit;
		logic               neg_emit;
		logic               last;
		logic [EADDR_W-1:0] edge_idx;
		logic [VTX_W-1:0]   out_idx;
	} bfsp_cmd_t;

	typedef struct packed {
		logic [ECNT_W-1:0] edge_count;
		logic [VCNT_W-1:0] vcount;
		logic              neg_found;
	} bfsp_status_t;

endpackage

// ----- rtl/core/bfsp_ctrl.sv -----
module bfsp_ctrl import bfsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CMD_W-1:0]   command,
	output logic               busy,
	output bfsp_cmd_t          cmd,
	input  bfsp_status_t       status
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_INIT     = 4'd1;
	localparam logic [3:0] ST_EDGE_RD  = 4'd2;
	localparam logic [3:0] ST_NODE_RD  = 4'd3;
	localparam logic [3:0] ST_CALC     = 4'd4;
	localparam logic [3:0] ST_UPD      = 4'd5;
	localparam logic [3:0] ST_FINISH   = 4'd6;
	localparam logic [3:0] ST_OUT_RD   = 4'd7;
	localparam logic [3:0] ST_OUT_EMIT = 4'd8;
	localparam logic [3:0] ST_NEG_EMIT = 4'd9;

	logic [3:0]         state_q;
	logic [EADDR_W-1:0] edge_idx_q;
	logic [VCNT_W-1:0]  pass_q;
	logic [VTX_W-1:0]   out_idx_q;
	logic               check_q;
	logic               accept;
	logic               edge_last;
	logic               pass_last;
	logic               out_last;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign edge_last = ((ECNT_W'(edge_idx_q) + ECNT_W'(1)) == status.edge_count);
	assign pass_last = ((pass_q + VCNT_W'(1)) == status.vcount);
	assign out_last  = ((VCNT_W'(out_idx_q) + VCNT_W'(1)) == status.vcount);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			edge_idx_q <= '0;
			pass_q     <= '0;
			out_idx_q  <= '0;
			check_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_RUN) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					edge_idx_q <= '0;
					pass_q     <= '0;
					out_idx_q  <= '0;
					check_q    <= 1'b0;
					if (status.edge_count == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_EDGE_RD;
					end
				end
				ST_EDGE_RD: state_q <= ST_NODE_RD;
				ST_NODE_RD: state_q <= ST_CALC;
				ST_CALC:    state_q <= ST_UPD;
				ST_UPD: begin
					if (edge_last) begin
						edge_idx_q <= '0;
						if (check_q) begin
							state_q <= ST_FINISH;
						end else begin
							// after the last relaxation pass comes the cycle check pass
							if (pass_last) begin
								check_q <= 1'b1;
							end else begin
								pass_q <= pass_q + VCNT_W'(1);
							end
							state_q <= ST_EDGE_RD;
						end
					end else begin
						edge_idx_q <= edge_idx_q + EADDR_W'(1);
						state_q    <= ST_EDGE_RD;
					end
				end
				ST_FINISH: begin
					if (status.neg_found) begin
						state_q <= ST_NEG_EMIT;
					end else begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_EMIT;
				ST_OUT_EMIT: begin
					if (out_last) begin
						state_q <= ST_IDLE;
					end else begin
						out_idx_q <= out_idx_q + VTX_W'(1);
						state_q   <= ST_OUT_RD;
					end
				end
				ST_NEG_EMIT: state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.init     = (state_q == ST_INIT);
		cmd.edge_rd  = (state_q == ST_EDGE_RD);
		cmd.node_rd  = (state_q == ST_NODE_RD);
		cmd.calc     = (state_q == ST_CALC);
		cmd.upd      = (state_q == ST_UPD);
		cmd.check    = check_q;
		cmd.out_rd   = (state_q == ST_OUT_RD);
		cmd.out_emit = (state_q == ST_OUT_EMIT);
		cmd.neg_emit = (state_q == ST_NEG_EMIT);
		cmd.last     = (state_q == ST_OUT_EMIT) && out_last;
		cmd.edge_idx = edge_idx_q;
		cmd.out_idx  = out_idx_q;
	end

	a_upd_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> $past(state_q) == ST_CALC)
		else $error("update step without a preceding calc step");

	a_neg_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NEG_EMIT |-> $past(state_q) == ST_FINISH && status.neg_found)
		else $error("negative cycle result without a finished check pass");

	a_out_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT_EMIT |-> (VCNT_W'(out_idx_q) < status.vcount))
		else $error("result index beyond vertex count");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> state_q == ST_IDLE)
		else $error("run did not end after its last result");

endmodule

// ----- rtl/core/bfsp_datapath.sv -----
module bfsp_datapath import bfsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bfsp_cmd_t                cmd,
	output bfsp_status_t             status,
	input  logic [CMD_W-1:0]         command,
	input  logic [FIELD_VW-1:0]      edge_source,
	input  logic [FIELD_VW-1:0]      edge_destination,
	input  logic signed [15:0]       edge_weight,
	input  logic [FIELD_VW-1:0]      start_vertex,
	input  logic                     cfg_valid,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     result_valid,
	output logic [FIELD_VW-1:0]      vertex,
	output logic signed [DIST_W-1:0] distance,
	output logic [FIELD_VW-1:0]      predecessor,
	output logic                     has_predecessor,
	output logic                     reachable,
	output logic                     negative_cycle,
	output logic                     last
);

	edge_rec_t          edge_mem [MAX_EDGES];
	logic [DIST_W-1:0]  dist_mem [MAX_VERTICES];
	logic [VTX_W-1:0]   pred_mem [MAX_VERTICES];

	logic [ECNT_W-1:0]       edge_count_q;
	logic [CFG_W-1:0]        vertex_count_q;
	logic [VCNT_W-1:0]       vcount;
	logic [VTX_W-1:0]        start_q;
	logic [MAX_VERTICES-1:0] reach_q;
	logic [MAX_VERTICES-1:0] pred_valid_q;
	logic                    neg_q;

	edge_rec_t          edge_s1;
	logic [DIST_W-1:0]  dist_a_q;
	logic [DIST_W-1:0]  dist_dst_s2;
	logic [VTX_W-1:0]   pred_rd_q;
	logic               cand_s2;
	logic               reach_dst_s2;
	logic [VTX_W-1:0]   src_s2;
	logic [VTX_W-1:0]   dst_s2;
	logic [WEIGHT_BITS-1:0] weight_s2;

	logic signed [DIST_W-1:0] alt_s3;
	logic signed [DIST_W-1:0] dist_dst_s3;
	logic               cand_s3;
	logic               reach_dst_s3;
	logic [VTX_W-1:0]   src_s3;
	logic [VTX_W-1:0]   dst_s3;

	logic [VTX_W-1:0]   rd_addr_a;
	logic               dist_we;
	logic [VTX_W-1:0]   dist_waddr;
	logic [DIST_W-1:0]  dist_wdata;
	logic               relax;
	logic signed [DIST_W:0] sum;
	logic signed [DIST_W-1:0] alt;
	logic               out_reach;
	logic               out_pv;

	// zero acts as one, anything above the table size as the table size
	always_comb begin
		if (vertex_count_q == '0) begin
			vcount = VCNT_W'(1);
		end else if (vertex_count_q > CFG_W'(MAX_VERTICES)) begin
			vcount = VCNT_W'(MAX_VERTICES);
		end else begin
			vcount = VCNT_W'(vertex_count_q);
		end
	end

	assign status.edge_count = edge_count_q;
	assign status.vcount     = vcount;
	assign status.neg_found  = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
			edge_count_q   <= '0;
		end else begin
			if (cfg_valid) begin
				vertex_count_q <= cfg_data;
			end
			if (cmd.accept && command == CMD_CLEAR) begin
				edge_count_q <= '0;
			end else if (cmd.accept && command == CMD_ADD
			             && edge_count_q < ECNT_W'(MAX_EDGES)) begin
				edge_count_q <= edge_count_q + ECNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && command == CMD_ADD && edge_count_q < ECNT_W'(MAX_EDGES)) begin
			edge_mem[edge_count_q[EADDR_W-1:0]] <= '{
				src:    VTX_W'(edge_source),
				dst:    VTX_W'(edge_destination),
				weight: edge_weight[WEIGHT_BITS-1:0]
			};
		end
		if (cmd.edge_rd) begin
			edge_s1 <= edge_mem[cmd.edge_idx];
		end
		if (cmd.accept && command == CMD_RUN) begin
			start_q <= VTX_W'(start_vertex);
		end
	end

	assign rd_addr_a = cmd.out_rd ? cmd.out_idx : edge_s1.src;

	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = dst_s3;
		dist_wdata = alt_s3;
		if (cmd.init) begin
			dist_we    = 1'b1;
			dist_waddr = start_q;
			dist_wdata = '0;
		end else if (relax) begin
			dist_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		if (cmd.node_rd || cmd.out_rd) begin
			dist_a_q <= dist_mem[rd_addr_a];
		end
		if (cmd.node_rd) begin
			dist_dst_s2 <= dist_mem[edge_s1.dst];
		end
	end

	always_ff @(posedge clk) begin
		if (relax) begin
			pred_mem[dst_s3] <= src_s3;
		end
		if (cmd.out_rd) begin
			pred_rd_q <= pred_mem[cmd.out_idx];
		end
	end

	// flags of the source and destination are taken with the distances
	always_ff @(posedge clk) begin
		if (cmd.node_rd) begin
			cand_s2      <= (VCNT_W'(edge_s1.src) < vcount) && (VCNT_W'(edge_s1.dst) < vcount)
			                && reach_q[edge_s1.src];
			reach_dst_s2 <= reach_q[edge_s1.dst];
			src_s2       <= edge_s1.src;
			dst_s2       <= edge_s1.dst;
			weight_s2    <= edge_s1.weight;
		end
	end

	assign sum = $signed({dist_a_q[DIST_W-1], dist_a_q})
	           + $signed({{(DIST_W + 1 - WEIGHT_BITS){weight_s2[WEIGHT_BITS-1]}}, weight_s2});

	always_comb begin
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			alt = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			alt = sum[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			alt_s3       <= alt;
			dist_dst_s3  <= dist_dst_s2;
			cand_s3      <= cand_s2;
			reach_dst_s3 <= reach_dst_s2;
			src_s3       <= src_s2;
			dst_s3       <= dst_s2;
		end
	end

	assign relax = cmd.upd && !cmd.check && cand_s3 && (!reach_dst_s3 || alt_s3 < dist_dst_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q      <= '0;
			pred_valid_q <= '0;
			neg_q        <= 1'b0;
		end else begin
			if (cmd.init) begin
				pred_valid_q <= '0;
				neg_q        <= 1'b0;
				if (VCNT_W'(start_q) < vcount) begin
					reach_q <= MAX_VERTICES'(1) << start_q;
				end else begin
					reach_q <= '0;
				end
			end else if (relax) begin
				reach_q[dst_s3]      <= 1'b1;
				pred_valid_q[dst_s3] <= 1'b1;
			end
			if (cmd.upd && cmd.check && cand_s3
			    && (!reach_dst_s3 || alt_s3 < dist_dst_s3)) begin
				neg_q <= 1'b1;
			end
		end
	end

	assign out_reach = reach_q[cmd.out_idx];
	assign out_pv    = out_reach && pred_valid_q[cmd.out_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.out_emit || cmd.neg_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_emit || cmd.neg_emit) begin
			vertex          <= cmd.out_emit ? FIELD_VW'(cmd.out_idx) : '0;
			distance        <= (cmd.out_emit && out_reach) ? dist_a_q : '0;
			predecessor     <= (cmd.out_emit && out_pv) ? FIELD_VW'(pred_rd_q) : '0;
			has_predecessor <= cmd.out_emit && out_pv;
			reachable       <= cmd.out_emit && out_reach;
			negative_cycle  <= cmd.neg_emit;
			last            <= cmd.neg_emit || cmd.last;
		end
	end

endmodule

// ----- rtl/core/bellman_ford_shortest_paths_core.sv -----
// single-source shortest paths over a loaded edge list
// input: a command transaction is taken at a clock edge with start high and busy low
//   clear (edge store emptied) and add edge (appended in load order, ignored when full)
//   leave busy low, so loads may follow back to back
//   run takes start_vertex and holds busy high until its last result is out
// run: vertex_count relaxation passes and a check pass over the edges, every edge
//   step being an edge store read, a table read, an add and a compare/write in turn,
//   then one result per vertex; a negative cycle gives a single result instead
// results: result_valid marks each result for one cycle, vertex order 0 .. n-1, last
//   flags the final one; the receiver has no way to stall them
// config: vertex_count is written through cfg_valid/cfg_ready while idle, always ready
// reset: edge store empty, vertex_count 32, no reachable vertices, controller idle
module bellman_ford_shortest_paths_core import bfsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [CMD_W-1:0]         command,
	input  logic [FIELD_VW-1:0]      edge_source,
	input  logic [FIELD_VW-1:0]      edge_destination,
	input  logic signed [15:0]       edge_weight,
	input  logic [FIELD_VW-1:0]      start_vertex,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     result_valid,
	output logic [FIELD_VW-1:0]      vertex,
	output logic signed [DIST_W-1:0] distance,
	output logic [FIELD_VW-1:0]      predecessor,
	output logic                     has_predecessor,
	output logic                     reachable,
	output logic                     negative_cycle,
	output logic                     last
);

	bfsp_cmd_t    cmd;
	bfsp_status_t status;

	assign cfg_ready = 1'b1;

	bfsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.cmd     (cmd),
		.status  (status)
	);

	bfsp_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.command          (command),
		.edge_source      (edge_source),
		.edge_destination (edge_destination),
		.edge_weight      (edge_weight),
		.start_vertex     (start_vertex),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.vertex           (vertex),
		.distance         (distance),
		.predecessor      (predecessor),
		.has_predecessor  (has_predecessor),
		.reachable        (reachable),
		.negative_cycle   (negative_cycle),
		.last             (last)
	);

endmodule

// ----- sim/bfsp_path_checker.sv -----
`timescale 1ns / 1ps

module bfsp_path_checker import bfsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [CMD_W-1:0]         command,
	input  logic [FIELD_VW-1:0]      edge_source,
	input  logic [FIELD_VW-1:0]      edge_destination,
	input  logic signed [15:0]       edge_weight,
	input  logic [FIELD_VW-1:0]      start_vertex,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     result_valid,
	input  logic [FIELD_VW-1:0]      vertex,
	input  logic signed [DIST_W-1:0] distance,
	input  logic [FIELD_VW-1:0]      predecessor,
	input  logic                     has_predecessor,
	input  logic                     reachable,
	input  logic                     negative_cycle,
	input  logic                     last,
	output int                       errors,
	output int                       pending
);

	typedef struct {
		logic [FIELD_VW-1:0]      vertex;
		logic signed [DIST_W-1:0] distance;
		logic [FIELD_VW-1:0]      predecessor;
		logic                     has_predecessor;
		logic                     reachable;
		logic                     negative_cycle;
		logic                     last;
	} path_result_t;

	edge_rec_t        edge_list[$];
	path_result_t     path_q[$];
	path_result_t     oldest;
	logic [CFG_W-1:0] vcount = VCOUNT_RESET;
	int               err_cnt = 0;
	int               pend_cnt = 0;

	longint           dist_tab[MAX_VERTICES];
	bit               reach_tab[MAX_VERTICES];
	logic [VTX_W-1:0] prev_tab[MAX_VERTICES];
	bit               prev_ok[MAX_VERTICES];

	assign errors  = err_cnt;
	assign pending = pend_cnt;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// true when the edge would lower its destination's distance
	function bit lowers(edge_rec_t e, int n, output longint alt);
		alt = 0;
		if (e.src >= n || e.dst >= n) return 0;
		if (!reach_tab[e.src]) return 0;
		alt = clamp32(dist_tab[e.src] + longint'($signed(e.weight)));
		return !reach_tab[e.dst] || alt < dist_tab[e.dst];
	endfunction

	function void predict_paths(logic [FIELD_VW-1:0] from_vertex);
		int           n;
		longint       alt;
		bit           neg;
		path_result_t res;
		n = (vcount == 0) ? 1 : ((vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount));
		for (int i = 0; i < MAX_VERTICES; i++) begin
			dist_tab[i]  = 0;
			reach_tab[i] = 0;
			prev_tab[i]  = '0;
			prev_ok[i]   = 0;
		end
		if (from_vertex < n)
			reach_tab[from_vertex] = 1;
		for (int p = 0; p < n; p++) begin
			foreach (edge_list[k]) begin
				if (lowers(edge_list[k], n, alt)) begin
					dist_tab[edge_list[k].dst]  = alt;
					reach_tab[edge_list[k].dst] = 1;
					prev_tab[edge_list[k].dst]  = edge_list[k].src;
					prev_ok[edge_list[k].dst]   = 1;
				end
			end
		end
		neg = 0;
		foreach (edge_list[k])
			if (lowers(edge_list[k], n, alt))
				neg = 1;
		if (neg) begin
			res = '{vertex: '0, distance: '0, predecessor: '0, has_predecessor: 1'b0,
				reachable: 1'b0, negative_cycle: 1'b1, last: 1'b1};
			path_q.push_back(res);
		end else begin
			for (int i = 0; i < n; i++) begin
				res.vertex          = FIELD_VW'(i);
				res.reachable       = reach_tab[i];
				res.distance        = reach_tab[i] ? DIST_W'(dist_tab[i]) : '0;
				res.has_predecessor = reach_tab[i] && prev_ok[i];
				res.predecessor     = res.has_predecessor ? prev_tab[i] : '0;
				res.negative_cycle  = 1'b0;
				res.last            = (i + 1 == n);
				path_q.push_back(res);
			end
		end
	endfunction

	function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_list.delete();
			path_q.delete();
			vcount   = VCOUNT_RESET;
			pend_cnt = 0;
		end else begin
			if (result_valid) begin
				if (path_q.size() == 0) begin
					$error("result for vertex %0d with no expectation waiting", vertex);
					err_cnt++;
				end else begin
					oldest = path_q.pop_front();
					compare_field("vertex", oldest.vertex, vertex);
					compare_field("distance", oldest.distance, distance);
					compare_field("predecessor", oldest.predecessor, predecessor);
					compare_field("has_predecessor", oldest.has_predecessor, has_predecessor);
					compare_field("reachable", oldest.reachable, reachable);
					compare_field("negative_cycle", oldest.negative_cycle, negative_cycle);
					compare_field("last", oldest.last, last);
				end
			end
			if (cfg_valid && cfg_ready)
				vcount = cfg_data;
			if (start && !busy) begin
				case (command)
					CMD_CLEAR: edge_list.delete();
					CMD_ADD: begin
						if (edge_list.size() < MAX_EDGES)
							edge_list.push_back('{src: edge_source, dst: edge_destination,
								weight: edge_weight});
					end
					CMD_RUN: predict_paths(start_vertex);
					default: ;
				endcase
			end
			pend_cnt = path_q.size();
		end
	end

endmodule

// ----- sim/bellman_ford_shortest_paths_core_tb.sv -----
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_core_tb;
	import bfsp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [CMD_W-1:0]         command = CMD_CLEAR;
	logic [FIELD_VW-1:0]      edge_source = '0;
	logic [FIELD_VW-1:0]      edge_destination = '0;
	logic signed [15:0]       edge_weight = '0;
	logic [FIELD_VW-1:0]      start_vertex = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     result_valid;
	logic [FIELD_VW-1:0]      vertex;
	logic signed [DIST_W-1:0] distance;
	logic [FIELD_VW-1:0]      predecessor;
	logic                     has_predecessor;
	logic                     reachable;
	logic                     negative_cycle;
	logic                     last;
	int                       errors;
	int                       pending;

	logic [CFG_W-1:0] vc = VCOUNT_RESET;
	bit               steady = 0;
	int               items = 0;
	int               loaded = 0;

	always #1 clk = ~clk;

	bellman_ford_shortest_paths_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.edge_source(edge_source), .edge_destination(edge_destination),
		.edge_weight(edge_weight), .start_vertex(start_vertex),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .vertex(vertex), .distance(distance),
		.predecessor(predecessor), .has_predecessor(has_predecessor),
		.reachable(reachable), .negative_cycle(negative_cycle), .last(last)
	);

	bfsp_path_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.edge_source(edge_source), .edge_destination(edge_destination),
		.edge_weight(edge_weight), .start_vertex(start_vertex),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .vertex(vertex), .distance(distance),
		.predecessor(predecessor), .has_predecessor(has_predecessor),
		.reachable(reachable), .negative_cycle(negative_cycle), .last(last),
		.errors(errors), .pending(pending)
	);

	function automatic int eff_n();
		return (vc == 0) ? 1 : ((vc > MAX_VERTICES) ? MAX_VERTICES : int'(vc));
	endfunction

	// mostly inside the vertex range in use, now and then anywhere
	function automatic logic [FIELD_VW-1:0] pick_vertex();
		if ($urandom_range(0, 9) != 0)
			return FIELD_VW'($urandom_range(0, eff_n() - 1));
		return FIELD_VW'($urandom);
	endfunction

	function automatic logic signed [15:0] pick_weight();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12) return 16'($urandom_range(0, 200));
		if (sel < 17) return 16'(0 - $urandom_range(1, 40));
		return 16'($urandom);
	endfunction

	function automatic logic [CFG_W-1:0] pick_vcount();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd32;
			3: return 6'd63;
			4: return CFG_W'($urandom_range(33, 62));
			default: return CFG_W'($urandom_range(2, 12));
		endcase
	endfunction

	task automatic issue(logic [CMD_W-1:0] cmd, logic [FIELD_VW-1:0] src,
			logic [FIELD_VW-1:0] dst, logic signed [15:0] w, logic [FIELD_VW-1:0] from);
		if (!steady) begin
			while ($urandom_range(0, 99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start            <= 1'b1;
		command          <= cmd;
		edge_source      <= src;
		edge_destination <= dst;
		edge_weight      <= w;
		start_vertex     <= from;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd != CMD_UNUSED) items++;
		if (cmd == CMD_CLEAR) loaded = 0;
		if (cmd == CMD_ADD) loaded++;
	endtask

	// sender holds off until the block is idle and every result is in
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_vcount(logic [CFG_W-1:0] v);
		while ($urandom_range(0, 99) < 31)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		vc = v;
	endtask

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int choice;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset vertex count, empty store, then a reachable negative cycle through extremes
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd0);
		issue(CMD_UNUSED, 5'd31, 5'd31, -16'sd1, 5'd31);
		issue(CMD_ADD, 5'd0, 5'd1, 16'sd32767, 5'd0);
		issue(CMD_ADD, 5'd1, 5'd2, -16'sd32768, 5'd0);
		issue(CMD_ADD, 5'd0, 5'd2, 16'sd5, 5'd0);
		issue(CMD_ADD, 5'd2, 5'd31, -16'sd1, 5'd0);
		issue(CMD_ADD, 5'd31, 5'd0, 16'sd1, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd31);
		wait_idle();
		// edges touching vertex 31 fall out of range, start out of range
		write_vcount(6'd3);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd5);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd2);
		wait_idle();
		write_vcount(6'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd0);
		wait_idle();
		write_vcount(6'd63);
		issue(CMD_CLEAR, 5'd31, 5'd31, 16'sd0, 5'd31);
		issue(CMD_ADD, 5'd31, 5'd30, -16'sd1, 5'd0);
		issue(CMD_ADD, 5'd30, 5'd31, 16'sd1, 5'd0);
		issue(CMD_ADD, 5'd31, 5'd31, 16'sd0, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd31);
		issue(CMD_ADD, 5'd5, 5'd5, -16'sd1, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd31);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd5);
		issue(CMD_CLEAR, 5'd0, 5'd0, 16'sd0, 5'd0);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd1);
		wait_idle();

		write_vcount(6'd1);
		issue(CMD_RUN, 5'd0, 5'd0, 16'sd0, 5'd0);
		issue(CMD_CLEAR, 5'd0, 5'd0, 16'sd0, 5'd0);
		wait_idle();
		write_vcount(6'd6);

		while (items < 160) begin
			steady = (items >= 50 && items < 100);
			choice = $urandom_range(0, 99);
			if (choice < 12) begin
				wait_idle();
				write_vcount(pick_vcount());
			end else if (choice < 27) begin
				issue(CMD_W'($urandom_range(0, 3)), 5'($urandom), 5'($urandom),
					16'($urandom), 5'($urandom));
			end else begin
				// usually a clear, then a handful of edges, one run
				if (loaded > 40 || $urandom_range(0, 4) != 0)
					issue(CMD_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
				k = $urandom_range(1, 12);
				repeat (k)
					issue(CMD_ADD, pick_vertex(), pick_vertex(), pick_weight(), 5'($urandom));
				issue(CMD_RUN, 5'($urandom), 5'($urandom), 16'($urandom), pick_vertex());
			end
		end
		steady = 0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- bellman_ford_shortest_paths_core.f -----
rtl/core/bfsp_pkg.sv
rtl/core/bfsp_ctrl.sv
rtl/core/bfsp_datapath.sv
rtl/core/bellman_ford_shortest_paths_core.sv
sim/bfsp_path_checker.sv
sim/bellman_ford_shortest_paths_core_tb.sv
